@@ design/ttf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle tangent frame package
// Field widths and stream bus widths shared by the tangent frame block.
// ----------------------------------------------------------------------------
package ttf_pkg;

    // Input item fields
    localparam int ID_W  = 16;
    localparam int POS_W = 32;
    localparam int UV_W  = 24;

    // Result component width, signed Q2.14
    localparam int COMP_W = 16;

    // Packed stream widths
    localparam int IN_TDATA_W  = ID_W + 3 * POS_W + 2 * UV_W;
    localparam int OUT_TDATA_W = ID_W + 6 * COMP_W;

    // Internal arithmetic widths
    localparam int DUV_W = UV_W + 1;             // texture coordinate delta
    localparam int EDGE_W = POS_W + 1;           // edge vector component
    localparam int PROD_W = DUV_W + EDGE_W;      // shared multiplier result
    localparam int VEC_W = PROD_W + 1;           // raw frame vector component
    localparam int MAG_W = VEC_W - 1;            // magnitude of a raw component
    localparam int SCALED_W = 16;                // block scaled magnitude
    localparam int SUMSQ_W = 2 * SCALED_W + 2;   // sum of three squares

endpackage : ttf_pkg
`default_nettype wire

@@ design/triangle_tangent_frame.sv @@
// A triangle list streams in one corner per transaction. The first two corners
// of a triangle are held; the third corner starts the computation and the block
// then returns three results, one per corner in arrival order, with tlast on the
// third. While a triangle is being worked on, i_tready stays low. Each result
// runs through one shared 33x25 multiplier and a one-bit-per-cycle divider and
// square root: the determinant and raw vectors come first, then for each vector
// block scaling, squaring and the three divide and square root passes. A
// degenerate result skips normalization, and each result holds until it is
// taken. The first two corners of a triangle are accepted back to back.
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle tangent frame
// Per-triangle tangent and bitangent from positions and texture coordinates,
// normalized to signed Q2.14 with a shared multiplier and bit-serial units.
// ----------------------------------------------------------------------------
module triangle_tangent_frame (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Fields from bit 0 up: vertex_id, pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire [ttf_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  wire                              i_tvalid,
    input  wire                              i_tlast,   // list_end
    output logic                             i_tready,
    // Fields from bit 0 up: out_vertex_id, tangent_x, tangent_y, tangent_z,
    // bitangent_x, bitangent_y, bitangent_z
    output logic [ttf_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic                             o_tuser,   // degenerate
    output logic                             o_tlast,   // last_of_triangle
    output logic                             o_tvalid,
    input  wire                              o_tready
);
    import ttf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL, S_ACC, S_NLOAD, S_SHIFT, S_SQMUL, S_SQACC,
        S_DINIT, S_DIV, S_SINIT, S_SQRT, S_STORE, S_EMIT
    } t_state;

    t_state r_state;

    // Corner slots; slot 0 is always the apex of the result being computed
    logic        [1:0]       r_cnt;
    logic        [ID_W-1:0]  r_id  [3];
    logic signed [POS_W-1:0] r_pos [3][3];
    logic signed [UV_W-1:0]  r_u   [3];
    logic signed [UV_W-1:0]  r_v   [3];

    // Sequencer counters
    logic [1:0] r_k;
    logic [3:0] r_j;
    logic       r_vsel;
    logic [1:0] r_i;
    logic [4:0] r_step;

    // Edge and texture deltas of the current apex
    logic signed [DUV_W-1:0]  r_du0, r_dv0, r_du1, r_dv1;
    logic signed [EDGE_W-1:0] r_e0 [3];
    logic signed [EDGE_W-1:0] r_e1 [3];

    // Shared multiplier and accumulator
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VEC_W-1:0]  r_acc;
    logic                     r_det_neg, r_det_zero;
    logic signed [VEC_W-1:0]  r_tan [3];
    logic signed [VEC_W-1:0]  r_bit [3];

    // Normalization
    logic [MAG_W-1:0]       r_m   [3];
    logic                   r_sgn [3];
    logic [2*SCALED_W-1:0]  r_sq  [3];
    logic [SUMSQ_W-1:0]     r_s;
    logic [SUMSQ_W:0]       r_rem;
    logic [30:0]            r_dlo;
    logic [30:0]            r_quo;
    logic [31:0]            r_rad;
    logic [19:0]            r_srem;
    logic [15:0]            r_root;

    // Result register
    logic signed [COMP_W-1:0] r_res [6];
    logic                     r_o_valid, r_o_degen, r_o_last;

    // Multiplier operand selection
    logic signed [EDGE_W-1:0] w_op_a;
    logic signed [DUV_W-1:0]  w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic        [3:0]        w_jj;
    logic        [1:0]        w_axis;
    logic        [SCALED_W-1:0] w_msel;

    always_comb begin
        w_jj   = r_j - 4'd2;
        w_axis = w_jj[3:2];
        w_msel = r_m[r_i][SCALED_W-1:0];
        w_op_a = '0;
        w_op_b = '0;
        if (r_state == S_SQMUL) begin
            w_op_a = EDGE_W'(w_msel);
            w_op_b = DUV_W'(w_msel);
        end else begin
            case (r_j)
                4'd0: begin
                    w_op_a = EDGE_W'(r_du0);
                    w_op_b = r_dv1;
                end
                4'd1: begin
                    w_op_a = EDGE_W'(r_du1);
                    w_op_b = r_dv0;
                end
                default: begin
                    case (w_jj[1:0])
                        2'd0: begin
                            w_op_a = r_e0[w_axis];
                            w_op_b = r_dv1;
                        end
                        2'd1: begin
                            w_op_a = r_e1[w_axis];
                            w_op_b = r_dv0;
                        end
                        2'd2: begin
                            w_op_a = r_e1[w_axis];
                            w_op_b = r_du0;
                        end
                        default: begin
                            w_op_a = r_e0[w_axis];
                            w_op_b = r_du1;
                        end
                    endcase
                end
            endcase
        end
        w_prod = w_op_a * w_op_b;
    end

    // Datapath helpers
    logic signed [VEC_W-1:0] w_diff;
    logic signed [VEC_W-1:0] w_raw [3];
    logic [MAG_W-1:0]        w_mor;
    logic [SUMSQ_W:0]        w_rem2;
    logic                    w_ge;
    logic [19:0]             w_cur;
    logic [19:0]             w_trial;
    logic [COMP_W-1:0]       w_q;
    logic [2:0]              w_base;

    always_comb begin
        w_diff = r_acc - VEC_W'(r_prod);
        for (int i = 0; i < 3; i++) begin
            w_raw[i] = r_vsel ? r_bit[i] : r_tan[i];
        end
        w_mor   = r_m[0] | r_m[1] | r_m[2];
        w_rem2  = {r_rem[SUMSQ_W-1:0], r_dlo[30]};
        w_ge    = (w_rem2 >= {1'b0, r_s});
        w_cur   = {r_srem[17:0], r_rad[31:30]};
        w_trial = {2'b00, r_root, 2'b01};
        w_q     = COMP_W'((17'(r_root) + 17'd1) >> 1);
        w_base  = r_vsel ? 3'd3 : 3'd0;
    end

    // Sequencer, datapath registers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_tvalid) begin
                        r_id[r_cnt]     <= i_tdata[15:0];
                        r_pos[r_cnt][0] <= i_tdata[47:16];
                        r_pos[r_cnt][1] <= i_tdata[79:48];
                        r_pos[r_cnt][2] <= i_tdata[111:80];
                        r_u[r_cnt]      <= i_tdata[135:112];
                        r_v[r_cnt]      <= i_tdata[159:136];
                        if (r_cnt == 2'd2) begin
                            r_cnt   <= 2'd0;
                            r_k     <= 2'd0;
                            r_state <= S_PREP;
                        end else if (i_tlast) begin
                            r_cnt <= 2'd0;
                        end else begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
                // Deltas from the apex in slot 0
                S_PREP: begin
                    r_du0 <= DUV_W'(r_u[1]) - DUV_W'(r_u[0]);
                    r_dv0 <= DUV_W'(r_v[1]) - DUV_W'(r_v[0]);
                    r_du1 <= DUV_W'(r_u[2]) - DUV_W'(r_u[0]);
                    r_dv1 <= DUV_W'(r_v[2]) - DUV_W'(r_v[0]);
                    for (int a = 0; a < 3; a++) begin
                        r_e0[a] <= EDGE_W'(r_pos[1][a]) - EDGE_W'(r_pos[0][a]);
                        r_e1[a] <= EDGE_W'(r_pos[2][a]) - EDGE_W'(r_pos[0][a]);
                    end
                    r_j     <= 4'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                // Even products load, odd products subtract and land
                S_ACC: begin
                    if (!r_j[0]) begin
                        r_acc <= VEC_W'(r_prod);
                    end else if (r_j == 4'd1) begin
                        r_det_neg  <= w_diff[VEC_W-1];
                        r_det_zero <= (w_diff == '0);
                    end else if (!w_jj[1]) begin
                        r_tan[w_axis] <= w_diff;
                    end else begin
                        r_bit[w_axis] <= w_diff;
                    end
                    if (r_j == 4'd13) begin
                        r_o_degen <= r_det_zero;
                        r_o_last  <= (r_k == 2'd2);
                        if (r_det_zero) begin
                            for (int n = 0; n < 6; n++) r_res[n] <= '0;
                            r_o_valid <= 1'b1;
                            r_state   <= S_EMIT;
                        end else begin
                            r_vsel  <= 1'b0;
                            r_state <= S_NLOAD;
                        end
                    end else begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                // Magnitudes and signs, with the determinant sign folded in
                S_NLOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= MAG_W'(w_raw[i][VEC_W-1] ? -w_raw[i] : w_raw[i]);
                        r_sgn[i] <= w_raw[i][VEC_W-1] ^ r_det_neg;
                    end
                    r_state <= S_SHIFT;
                end
                // Block scaling, one bit per cycle
                S_SHIFT: begin
                    if (w_mor == '0) begin
                        for (int i = 0; i < 3; i++) r_res[w_base + 3'(i)] <= '0;
                        if (!r_vsel) begin
                            r_vsel  <= 1'b1;
                            r_state <= S_NLOAD;
                        end else begin
                            r_o_valid <= 1'b1;
                            r_state   <= S_EMIT;
                        end
                    end else if (w_mor[MAG_W-1:SCALED_W] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else begin
                        r_i     <= 2'd0;
                        r_state <= S_SQMUL;
                    end
                end
                S_SQMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_sq[r_i] <= r_prod[2*SCALED_W-1:0];
                    r_s <= ((r_i == 2'd0) ? '0 : r_s) + SUMSQ_W'(r_prod[2*SCALED_W-1:0]);
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_state <= S_DINIT;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_SQMUL;
                    end
                end
                // Quotient of square * 2^30 by the sum of squares
                S_DINIT: begin
                    r_rem   <= (SUMSQ_W + 1)'(r_sq[r_i] >> 1);
                    r_dlo   <= {r_sq[r_i][0], 30'd0};
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? (w_rem2 - {1'b0, r_s}) : w_rem2;
                    r_quo  <= {r_quo[29:0], w_ge};
                    r_dlo  <= {r_dlo[29:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd30) r_state <= S_SINIT;
                end
                S_SINIT: begin
                    r_rad   <= {1'b0, r_quo};
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_SQRT;
                end
                // Integer square root, two radicand bits per cycle
                S_SQRT: begin
                    if (w_cur >= w_trial) begin
                        r_srem <= w_cur - w_trial;
                        r_root <= {r_root[14:0], 1'b1};
                    end else begin
                        r_srem <= w_cur;
                        r_root <= {r_root[14:0], 1'b0};
                    end
                    r_rad  <= {r_rad[29:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd15) r_state <= S_STORE;
                end
                // Largest q with (2q-1)^2 within the quotient is (root+1)/2
                S_STORE: begin
                    r_res[w_base + {1'b0, r_i}] <= r_sgn[r_i] ? -w_q : w_q;
                    if (r_i == 2'd2) begin
                        if (!r_vsel) begin
                            r_vsel  <= 1'b1;
                            r_state <= S_NLOAD;
                        end else begin
                            r_o_valid <= 1'b1;
                            r_state   <= S_EMIT;
                        end
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DINIT;
                    end
                end
                // Hold the result until the transaction completes
                S_EMIT: begin
                    if (o_tready) begin
                        r_o_valid <= 1'b0;
                        for (int s = 0; s < 3; s++) begin
                            r_id[s] <= r_id[(s + 1) % 3];
                            r_u[s]  <= r_u[(s + 1) % 3];
                            r_v[s]  <= r_v[(s + 1) % 3];
                            for (int a = 0; a < 3; a++) r_pos[s][a] <= r_pos[(s + 1) % 3][a];
                        end
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_PREP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Port drive
    assign i_tready = (r_state == S_IDLE);
    assign o_tvalid = r_o_valid;
    assign o_tuser  = r_o_degen;
    assign o_tlast  = r_o_last;
    assign o_tdata  = {r_res[5], r_res[4], r_res[3], r_res[2], r_res[1], r_res[0], r_id[0]};

    // A pending result keeps the input side closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !i_tready)
        else $error("input ready while a result is pending");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_s}))
        else $error("divider remainder out of range");

    // Square root never exceeds the unit scale
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> (r_root <= 16'd32768))
        else $error("square root beyond unit scale");

    // A degenerate result carries zero vectors
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_degen) |-> (o_tdata[OUT_TDATA_W-1:ID_W] == '0))
        else $error("degenerate result with nonzero vectors");

endmodule : triangle_tangent_frame
`default_nettype wire

@@ dv/triangle_tangent_frame_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent frame testbench
// Streams triangle corners into the block, predicts the unit tangent and
// bitangent of every corner in fixed point and checks each result in order.
// A short directed list covers field extremes, degenerate UVs, zero-length
// vectors and lists that end on a partial triangle; random triangles follow.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_tb;
    import ttf_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [UV_W-1:0]  u;
        logic [UV_W-1:0]  v;
        logic             last;
        logic             drain;   // hold off until every result has come
    } t_corner;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [3*COMP_W-1:0] tan;   // x in the lowest bits
        logic [3*COMP_W-1:0] bit_t; // x in the lowest bits
        logic              degen;
        logic              last;
    } t_frame;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  i_tdata = '0;
    logic                   i_tvalid = 1'b0;
    logic                   i_tlast = 1'b0;
    logic                   i_tready;
    logic [OUT_TDATA_W-1:0] o_tdata;
    logic                   o_tuser;
    logic                   o_tlast;
    logic                   o_tvalid;
    logic                   o_tready = 1'b0;

    triangle_tangent_frame i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tdata (i_tdata),
        .i_tvalid(i_tvalid),
        .i_tlast (i_tlast),
        .i_tready(i_tready),
        .o_tdata (o_tdata),
        .o_tuser (o_tuser),
        .o_tlast (o_tlast),
        .o_tvalid(o_tvalid),
        .o_tready(o_tready)
    );

    t_corner pending_corners[$];
    t_frame  expected_frames[$];
    int      mismatches = 0;
    int      corners_sent = 0;
    int      corners_total = 0;

    // Predictor state: corners held for the triangle under construction.
    int               held_count = 0;
    logic [ID_W-1:0]  held_id[2];
    longint           held_pos[2][3];
    longint           held_uv[2][2];

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Block scaled normalization to Q2.14, three components packed x first.
    function automatic logic [3*COMP_W-1:0] unit_vector(longint rx, longint ry, longint rz);
        longint          raw[3];
        longint unsigned m[3];
        longint unsigned maxm, s, rhs, tt, lo, hi, mid;
        int              sh;
        logic [3*COMP_W-1:0] res;
        raw[0] = rx; raw[1] = ry; raw[2] = rz;
        maxm = 0; s = 0; res = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (raw[i] < 0) ? longint'(-raw[i]) : longint'(raw[i]);
            if (m[i] > maxm) maxm = m[i];
        end
        if (maxm == 0) return '0;
        sh = 0;
        while ((maxm >> sh) >= 64'd65536) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            s += m[i] * m[i];
        end
        for (int i = 0; i < 3; i++) begin
            rhs = (m[i] * m[i]) << 30;
            lo = 0; hi = 16384;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                tt = 2 * mid - 1;
                if (tt * tt * s <= rhs) lo = mid; else hi = mid - 1;
            end
            res[i*COMP_W +: COMP_W] = (raw[i] < 0) ? COMP_W'(-lo) : COMP_W'(lo);
        end
        return res;
    endfunction

    // Update the predictor with one accepted corner; a third corner yields three frames.
    task automatic take_corner(t_corner c);
        logic [ID_W-1:0] id[3];
        longint p[3][3];
        longint uv[3][2];
        longint du0, dv0, du1, dv1, det, e0, e1;
        longint t[3];
        longint b[3];
        int c1, c2;
        t_frame f;
        if (held_count < 2) begin
            if (c.last) begin
                held_count = 0;
            end else begin
                held_id[held_count] = c.id;
                held_pos[held_count][0] = longint'($signed(c.px));
                held_pos[held_count][1] = longint'($signed(c.py));
                held_pos[held_count][2] = longint'($signed(c.pz));
                held_uv[held_count][0] = longint'($signed(c.u));
                held_uv[held_count][1] = longint'($signed(c.v));
                held_count++;
            end
            return;
        end
        for (int k = 0; k < 2; k++) begin
            id[k] = held_id[k];
            for (int a = 0; a < 3; a++) p[k][a] = held_pos[k][a];
            for (int a = 0; a < 2; a++) uv[k][a] = held_uv[k][a];
        end
        id[2] = c.id;
        p[2][0] = longint'($signed(c.px));
        p[2][1] = longint'($signed(c.py));
        p[2][2] = longint'($signed(c.pz));
        uv[2][0] = longint'($signed(c.u));
        uv[2][1] = longint'($signed(c.v));
        held_count = 0;
        for (int k = 0; k < 3; k++) begin
            c1 = (k + 1) % 3;
            c2 = (k + 2) % 3;
            du0 = uv[c1][0] - uv[k][0];
            dv0 = uv[c1][1] - uv[k][1];
            du1 = uv[c2][0] - uv[k][0];
            dv1 = uv[c2][1] - uv[k][1];
            det = du0 * dv1 - du1 * dv0;
            f = '0;
            f.id = id[k];
            f.last = (k == 2);
            if (det == 0) begin
                f.degen = 1'b1;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    e0 = p[c1][a] - p[k][a];
                    e1 = p[c2][a] - p[k][a];
                    t[a] = dv1 * e0 - dv0 * e1;
                    b[a] = du0 * e1 - du1 * e0;
                    if (det < 0) begin
                        t[a] = -t[a];
                        b[a] = -b[a];
                    end
                end
                f.tan = unit_vector(t[0], t[1], t[2]);
                f.bit_t = unit_vector(b[0], b[1], b[2]);
            end
            expected_frames.push_back(f);
        end
    endtask

    task automatic add_corner(logic [15:0] id, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [23:0] u, logic [23:0] v, logic last);
        t_corner c;
        c.id = id; c.px = x; c.py = y; c.pz = z; c.u = u; c.v = v;
        c.last = last; c.drain = 1'b0;
        pending_corners.push_back(c);
    endtask

    // Random position or UV component: full range or a small window around zero.
    function automatic logic [31:0] rand_pos(bit narrow);
        logic [31:0] r;
        r = $urandom;
        if (narrow) r = {{12{r[19]}}, r[19:0]};
        return r;
    endfunction

    function automatic logic [23:0] rand_uv(bit narrow);
        logic [23:0] r;
        r = 24'($urandom);
        if (narrow) r = {{8{r[15]}}, r[15:0]};
        return r;
    endfunction

    // Stimulus.
    initial begin
        int kind, n;
        bit narrow, flat_uv, same_pos;
        logic [31:0] bx, by, bz;
        logic [23:0] bu, bv;

        // Field extremes: min and max positions, UV corners of the full range.
        add_corner(16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000, 24'h000000, 1'b0);
        add_corner(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7FFFFF, 24'h000000, 1'b0);
        add_corner(16'h5A5A, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h000000, 24'h800000, 1'b0);
        // Opposite winding in UV space, positive determinant.
        add_corner(16'h0001, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'h800000, 24'h7FFFFF, 1'b0);
        add_corner(16'h0002, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 24'h7FFFFF, 24'h800000, 1'b0);
        add_corner(16'h0003, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        // Zero determinant: identical texture coordinates.
        add_corner(16'h0010, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h012345, 24'h054321, 1'b0);
        add_corner(16'h0011, 32'hFFFF_0000, 32'h0000_0000, 32'h0005_0000, 24'h012345, 24'h054321, 1'b0);
        add_corner(16'h0012, 32'h0000_8000, 32'h0007_0000, 32'hFFFE_0000, 24'h012345, 24'h054321, 1'b0);
        // Zero-length vectors: all corners at one position.
        add_corner(16'h0020, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 24'h000000, 24'h000000, 1'b0);
        add_corner(16'h0021, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 24'h010000, 24'h000000, 1'b0);
        add_corner(16'h0022, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 24'h000000, 24'h010000, 1'b0);
        // List end on the first corner, then on the second corner.
        add_corner(16'h0030, 32'h0001_0000, 32'h0, 32'h0, 24'h0, 24'h0, 1'b1);
        add_corner(16'h0031, 32'h0001_0000, 32'h0, 32'h0, 24'h0, 24'h0, 1'b0);
        add_corner(16'h0032, 32'h0, 32'h0001_0000, 32'h0, 24'h010000, 24'h0, 1'b1);
        // List end on the third corner emits the triangle.
        add_corner(16'h0040, 32'h0, 32'h0, 32'h0, 24'h0, 24'h0, 1'b0);
        add_corner(16'h0041, 32'h0002_0000, 32'h0, 32'h0, 24'h020000, 24'h0, 1'b0);
        add_corner(16'h0042, 32'h0, 32'h0003_0000, 32'h0, 24'h0, 24'h030000, 1'b1);

        // Random part: mostly whole triangles, some broken ones.
        while (pending_corners.size() < 430) begin
            kind = $urandom_range(0, 99);
            narrow = $urandom_range(0, 1);
            if (kind < 85) begin
                flat_uv = ($urandom_range(0, 15) == 0);
                same_pos = ($urandom_range(0, 15) == 0);
                bx = rand_pos(narrow); by = rand_pos(narrow); bz = rand_pos(narrow);
                bu = rand_uv(narrow); bv = rand_uv(narrow);
                for (int k = 0; k < 3; k++) begin
                    add_corner(16'($urandom),
                               same_pos ? bx : rand_pos(narrow),
                               same_pos ? by : rand_pos(narrow),
                               same_pos ? bz : rand_pos(narrow),
                               flat_uv ? bu : rand_uv(narrow),
                               flat_uv ? bv : rand_uv(narrow),
                               (k == 2) && ($urandom_range(0, 9) == 0));
                end
            end else begin
                n = $urandom_range(1, 2);
                for (int k = 0; k < n; k++)
                    add_corner(16'($urandom), rand_pos(narrow), rand_pos(narrow),
                               rand_pos(narrow), rand_uv(narrow), rand_uv(narrow), k == n - 1);
            end
        end
        // Once in the middle the sender waits for the block to drain.
        pending_corners[230].drain = 1'b1;
        corners_total = pending_corners.size();
    end

    // Reset.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: bursts of transactions separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_corner c;
        if (!i_rst_n) begin
            i_tvalid <= 1'b0;
        end else begin
            if (i_tvalid && i_tready) begin
                take_corner(t_corner'({i_tdata[ID_W-1:0],
                                       i_tdata[ID_W +: POS_W],
                                       i_tdata[ID_W+POS_W +: POS_W],
                                       i_tdata[ID_W+2*POS_W +: POS_W],
                                       i_tdata[ID_W+3*POS_W +: UV_W],
                                       i_tdata[ID_W+3*POS_W+UV_W +: UV_W],
                                       i_tlast, 1'b0}));
                corners_sent++;
            end
            if (!i_tvalid || i_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_tvalid <= 1'b0;
                end else if (pending_corners.size() > 0 &&
                             (!pending_corners[0].drain || expected_frames.size() == 0)) begin
                    c = pending_corners.pop_front();
                    i_tdata <= {c.v, c.u, c.pz, c.py, c.px, c.id};
                    i_tlast <= c.last;
                    i_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: alternating ready and stall stretches.
    int ready_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else begin
            o_tready <= ~o_tready;
            ready_left = o_tready ? $urandom_range(0, 20) : $urandom_range(0, 60);
        end
    end

    // Monitor: compare each result transaction with the oldest expected frame.
    always @(posedge i_clk) begin
        t_frame f;
        if (i_rst_n && o_tvalid && o_tready) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: tdata=%h tuser=%b tlast=%b",
                             o_tdata, o_tuser, o_tlast);
            end else begin
                f = expected_frames.pop_front();
                if (o_tdata[ID_W-1:0] !== f.id ||
                    o_tdata[ID_W +: 3*COMP_W] !== f.tan ||
                    o_tdata[ID_W+3*COMP_W +: 3*COMP_W] !== f.bit_t ||
                    o_tuser !== f.degen || o_tlast !== f.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected id=%h tan=%h bit=%h deg=%b last=%b, got id=%h tan=%h bit=%h deg=%b last=%b",
                                 f.id, f.tan, f.bit_t, f.degen, f.last,
                                 o_tdata[ID_W-1:0], o_tdata[ID_W +: 3*COMP_W],
                                 o_tdata[ID_W+3*COMP_W +: 3*COMP_W], o_tuser, o_tlast);
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (corners_total > 0);
        wait (corners_sent == corners_total);
        wait (expected_frames.size() == 0);
        repeat (1500) @(posedge i_clk);
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
design/ttf_pkg.sv
design/triangle_tangent_frame.sv
dv/triangle_tangent_frame_tb.sv
